// ===== sv/bds_pkg.sv =====
// Shared constants and types for the 2x2 box downsampler.
`default_nettype none

package bds_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 1;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_W     = 3 * SUM_W;
    localparam int CMP_W      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } bds_cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_done;
    } bds_result_t;

endpackage

`default_nettype wire

// ===== sv/bds_line_ram.sv =====
// Simple dual-port line store with registered read data.
`default_nettype none

module bds_line_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 27
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bds_out_skid.sv =====
// Output register with one skid entry for the result channel.
`default_nettype none

module bds_out_skid (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire bds_pkg::bds_result_t in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    output bds_pkg::bds_result_t      out_data,
    input  wire logic                 out_ready
);
    import bds_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    bds_result_t out_data_reg;
    bds_result_t skid_data_reg;
    logic        out_free;

    assign out_free  = out_ready || !out_valid_reg;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/box_downsample_2x2_unit.sv =====
// Top level of the 2x2 box downsampler: raster counters, pair sums and line store.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  s_       | s_valid / s_ready  | s_red_in, s_green_in, s_blue_in
//  m_       | m_valid / m_ready  | m_red_out, m_green_out, m_blue_out, m_frame_done
//  cfg_     | cfg_we             | cfg_index, cfg_data
//
// One pixel per cycle unless the skid is full; one line RAM write or read per pair.
// The odd-column pixel of an odd row loads its result into the m_ register or skid.
// The row-above pair sums are read from the line RAM on the even-column pixel.
// Reset clears counters and valid flags and sets 256x256; line RAM stays undefined.
// A stalled m_ side fills the skid entry, after which s_ready drops.
`default_nettype none

module box_downsample_2x2_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bds_pkg::PIX_W-1:0]     s_red_in,
    input  wire logic [bds_pkg::PIX_W-1:0]     s_green_in,
    input  wire logic [bds_pkg::PIX_W-1:0]     s_blue_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [bds_pkg::PIX_W-1:0]     m_red_out,
    output logic      [bds_pkg::PIX_W-1:0]     m_green_out,
    output logic      [bds_pkg::PIX_W-1:0]     m_blue_out,
    output logic                               m_frame_done,
    input  wire logic                          cfg_we,
    input  wire bds_pkg::bds_cfg_idx_t         cfg_index,
    input  wire logic [bds_pkg::DIM_W-1:0]     cfg_data
);
    import bds_pkg::*;

    logic [COL_W:0]     width_reg;
    logic [ROW_W:0]     height_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_next;
    logic [3*PIX_W-1:0] left_reg;

    logic               accept;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic [CMP_W-1:0]   cfg_ext;
    logic [CMP_W-1:0]   width_clamped;
    logic [DIM_W-1:0]   height_clamped;

    logic [SUM_W-1:0]   pair_r, pair_g, pair_b;
    logic [LINE_W-1:0]  above;
    logic [SUM_W:0]     sum_r, sum_g, sum_b;
    logic               line_wr, line_rd;
    bds_result_t        result;
    logic               result_valid;
    bds_result_t        m_data;

    assign accept  = s_valid && s_ready;
    assign col_inc = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_inc = {1'b0, row_reg} + (ROW_W+1)'(1);

    // Clamp register writes to the legal range once, at write time.
    always_comb begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_ext == '0) begin
            width_clamped = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
            width_clamped = CMP_W'(MAX_WIDTH);
        end else begin
            width_clamped = cfg_ext;
        end
        if (cfg_data == '0) begin
            height_clamped = DIM_W'(1);
        end else if (cfg_data > DIM_W'(MAX_HEIGHT)) begin
            height_clamped = DIM_W'(MAX_HEIGHT);
        end else begin
            height_clamped = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= (COL_W+1)'(256);
            height_reg <= (ROW_W+1)'(256);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= width_clamped[COL_W:0];
                CFG_IMAGE_HEIGHT: height_reg <= height_clamped[ROW_W:0];
                default: ;
            endcase
        end
    end

    // Raster position of the next pixel.
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= width_reg) begin
            col_next = '0;
            row_next = (row_inc >= height_reg) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !col_reg[0]) begin
            left_reg <= {s_blue_in, s_green_in, s_red_in};
        end
    end

    assign pair_r = {1'b0, left_reg[PIX_W-1:0]}         + {1'b0, s_red_in};
    assign pair_g = {1'b0, left_reg[2*PIX_W-1:PIX_W]}   + {1'b0, s_green_in};
    assign pair_b = {1'b0, left_reg[3*PIX_W-1:2*PIX_W]} + {1'b0, s_blue_in};

    // Even rows store pair sums; odd rows fetch them on the even column.
    assign line_wr = accept && col_reg[0] && !row_reg[0];
    assign line_rd = accept && !col_reg[0] && row_reg[0];

    bds_line_ram #(
        .DEPTH (LINE_DEPTH),
        .WIDTH (LINE_W)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_wr),
        .wr_addr (col_reg[COL_W-1:1]),
        .wr_data ({pair_b, pair_g, pair_r}),
        .rd_en   (line_rd),
        .rd_addr (col_reg[COL_W-1:1]),
        .rd_data (above)
    );

    assign sum_r = {1'b0, above[SUM_W-1:0]}         + {1'b0, pair_r};
    assign sum_g = {1'b0, above[2*SUM_W-1:SUM_W]}   + {1'b0, pair_g};
    assign sum_b = {1'b0, above[3*SUM_W-1:2*SUM_W]} + {1'b0, pair_b};

    assign result_valid = accept && col_reg[0] && row_reg[0];

    always_comb begin
        result.red        = sum_r[SUM_W:2];
        result.green      = sum_g[SUM_W:2];
        result.blue       = sum_b[SUM_W:2];
        result.frame_done = (col_inc == {width_reg[COL_W:1], 1'b0})
                         && (row_inc == {height_reg[ROW_W:1], 1'b0});
    end

    bds_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (result_valid),
        .in_data   (result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (m_data),
        .out_ready (m_ready)
    );

    assign m_red_out    = m_data.red;
    assign m_green_out  = m_data.green;
    assign m_blue_out   = m_data.blue;
    assign m_frame_done = m_data.frame_done;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the 2x2 box downsampler: random raster frames with handshake gaps.
`timescale 1ns / 1ps

module tb;
    import bds_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } pair_t;

    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [PIX_W-1:0]  s_red_in = '0;
    logic [PIX_W-1:0]  s_green_in = '0;
    logic [PIX_W-1:0]  s_blue_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PIX_W-1:0]  m_red_out;
    logic [PIX_W-1:0]  m_green_out;
    logic [PIX_W-1:0]  m_blue_out;
    logic              m_frame_done;
    logic              cfg_we = 1'b0;
    bds_cfg_idx_t      cfg_index = CFG_IMAGE_WIDTH;
    logic [DIM_W-1:0]  cfg_data = '0;

    box_downsample_2x2_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_frame_done (m_frame_done),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // pixels waiting for the driver, block means waiting for the output port
    pixel_t      pixel_q[$];
    bds_result_t block_means[$];

    // downsampler shadow state
    logic [DIM_W-1:0] width_reg = 11'd256;
    logic [DIM_W-1:0] height_reg = 11'd256;
    int unsigned      x_pos = 0;
    int unsigned      y_pos = 0;
    pixel_t           even_px = '0;
    pair_t            row_pair_sums[LINE_DEPTH];

    int errors = 0;
    int pixels_taken = 0;
    int means_checked = 0;
    int settings_used = 0;
    int cycle_count = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic take_pixel(input pixel_t px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      slot;
        pair_t            pair;
        pair_t            above;
        logic [SUM_W:0]   sum_r;
        logic [SUM_W:0]   sum_g;
        logic [SUM_W:0]   sum_b;
        bds_result_t      mean;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        slot = (x_pos >> 1) % LINE_DEPTH;
        if ((x_pos & 1) == 0) begin
            even_px = px;
        end else begin
            pair.red   = SUM_W'(even_px.red) + SUM_W'(px.red);
            pair.green = SUM_W'(even_px.green) + SUM_W'(px.green);
            pair.blue  = SUM_W'(even_px.blue) + SUM_W'(px.blue);
            if ((y_pos & 1) == 0) begin
                row_pair_sums[slot] = pair;
            end else begin
                above = row_pair_sums[slot];
                sum_r = (SUM_W+1)'(above.red) + (SUM_W+1)'(pair.red);
                sum_g = (SUM_W+1)'(above.green) + (SUM_W+1)'(pair.green);
                sum_b = (SUM_W+1)'(above.blue) + (SUM_W+1)'(pair.blue);
                mean.red   = sum_r[SUM_W:2];
                mean.green = sum_g[SUM_W:2];
                mean.blue  = sum_b[SUM_W:2];
                mean.frame_done = (w >= 2) && (h >= 2) &&
                                  (x_pos == 2 * (w / 2) - 1) && (y_pos == 2 * (h / 2) - 1);
                block_means.push_back(mean);
            end
        end
        if (x_pos + 1 >= w) begin
            x_pos = 0;
            y_pos = (y_pos + 1 >= h) ? 0 : y_pos + 1;
        end else begin
            x_pos = x_pos + 1;
        end
    endtask

    // driver: bursts of random length, random gaps in between
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        pixel_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                take_pixel({s_red_in, s_green_in, s_blue_in});
                pixels_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    nxt = pixel_q.pop_front();
                    s_valid    <= 1'b1;
                    s_red_in   <= nxt.red;
                    s_green_in <= nxt.green;
                    s_blue_in  <= nxt.blue;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 32);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(10, 30);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // monitor and receiver stall pattern
    ready_mode_t ready_mode = RDY_ALWAYS;
    int mode_left = 0;

    always @(posedge aclk) begin
        bds_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (block_means.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d fd=%0d",
                         $time, m_red_out, m_green_out, m_blue_out, m_frame_done);
            end else begin
                want = block_means.pop_front();
                check_field("red_out", want.red, m_red_out);
                check_field("green_out", want.green, m_green_out);
                check_field("blue_out", want.blue, m_blue_out);
                check_field("frame_done", want.frame_done, m_frame_done);
                means_checked++;
            end
        end
        if (mode_left == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_HALF:   m_ready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:    m_ready <= ~m_ready;
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input int r, input int g, input int b);
        pixel_q.push_back({PIX_W'(r), PIX_W'(g), PIX_W'(b)});
    endtask

    task automatic push_random(input int n);
        repeat (n) pixel_q.push_back({rand_chan(), rand_chan(), rand_chan()});
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (pixel_q.size() != 0 || s_valid || block_means.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input bds_cfg_idx_t idx, input int val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(val);
        if (idx == CFG_IMAGE_WIDTH) width_reg = DIM_W'(val);
        else height_reg = DIM_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input int w, input int h);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        settings_used++;
    endtask

    // feed pixels until the raster position wraps back to the frame start
    task automatic finish_frame();
        int unsigned w;
        int unsigned h;
        forever begin
            wait_idle();
            if (x_pos == 0 && y_pos == 0) break;
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            if (y_pos < h && x_pos < w) push_random((h - y_pos) * w - x_pos);
            else push_random(1);
        end
    endtask

    function automatic int pick_dim(input int hi);
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1);
            1:       return $urandom_range(hi + 1, 4 * hi);
            default: return $urandom_range(2, hi);
        endcase
    endfunction

    initial begin
        int w;
        int h;
        int n;
        int random_items;
        random_items = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset dimensions: two rows, then stop mid-frame and shrink to 1x1
        push_random(512);
        wait_idle();
        set_dims(1, 1);
        finish_frame();

        // 2x2 frames: channel extremes and a mean that truncates
        set_dims(2, 2);
        push_pixel(255, 0, 1);
        push_pixel(255, 0, 2);
        push_pixel(255, 0, 3);
        push_pixel(255, 0, 255);
        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(255, 255, 255);
        push_pixel(255, 255, 255);
        wait_idle();

        // odd last column and row are dropped
        set_dims(3, 3);
        push_random(9);
        wait_idle();

        // single-pixel rows or columns never complete a block
        set_dims(1, 2);
        push_random(2);
        wait_idle();
        set_dims(2, 1);
        push_random(2);
        wait_idle();
        set_dims(0, 0);
        push_random(1);
        wait_idle();

        // width shrinks mid-frame on an odd row
        set_dims(8, 4);
        push_random(11);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 2);
        finish_frame();

        // height shrinks mid-frame on an even row
        set_dims(4, 6);
        push_random(10);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 2);
        finish_frame();

        // register values past the top of the range clamp instead of wrapping
        set_dims(1026, 2);
        push_random(4);
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 2);
        finish_frame();
        set_dims(2, 1026);
        push_random(8);
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 2);
        finish_frame();

        while (random_items < 400) begin
            w = pick_dim(12);
            h = pick_dim(4);
            set_dims(w, h);
            n = $urandom_range(1, 2) * clamp_dim(w, MAX_WIDTH) * clamp_dim(h, MAX_HEIGHT);
            push_random(n);
            if (w >= 2 && h >= 2) random_items += n;
            wait_idle();
        end

        $display("Run covered %0d pixels and %0d block means over %0d image sizes,",
                 pixels_taken, means_checked, settings_used);
        $display("including clamped sizes, odd edges and mid-frame size changes.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== box_downsample_2x2_unit.f =====
sv/bds_pkg.sv
sv/bds_line_ram.sv
sv/bds_out_skid.sv
sv/box_downsample_2x2_unit.sv
verif/tb.sv
